>>> hw/rtl/bgcd_pkg.sv
// shared types, constants and the level ladder for the battery gauge
`timescale 1ns / 1ps

package bgcd_pkg;

    localparam int RAW_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int MV_W    = 18;
    localparam int LEVEL_W = 4;

    // millivolts = raw * 36300 / 65536
    localparam logic [15:0] ROLL_SCALE = 16'd36300;

    // reciprocal multipliers, exact for the magnitudes that reach them
    localparam logic [22:0] RECIP11       = 23'd6100806;
    localparam int          RECIP11_SHIFT = 26;
    localparam logic [23:0] RECIP17       = 24'd15790321;
    localparam int          RECIP17_SHIFT = 28;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 4'd11;

    typedef logic signed [MV_W-1:0]   mv_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    localparam logic signed [10:0] START_DIFF_RST = -11'sd25;
    localparam logic [9:0]         STOP_DIFF_RST  = 10'd25;
    localparam logic [12:0]        START_VOLT_RST = 13'd4200;

    localparam mv_t LADDER [10] = '{
        18'sd3478, 18'sd3549, 18'sd3619, 18'sd3655, 18'sd3725,
        18'sd3761, 18'sd3866, 18'sd3927, 18'sd4027, 18'sd4175
    };

    typedef enum logic [1:0] {
        REG_START_DIFF = 2'd0,
        REG_STOP_DIFF  = 2'd1,
        REG_START_VOLT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [10:0] start_diff;
        logic [9:0]         stop_diff;
        logic [12:0]        start_volt;
    } cfg_t;

    // item between the scaling stage and the tracking stage
    typedef struct packed {
        logic [RAW_W-1:0] rolling;
        diff_t            diff;
        logic             mute;
        logic             restart;
    } mid_t;

    // ladder thresholds rise, so the level is the count of those exceeded
    function automatic logic [LEVEL_W-1:0] level_of(input mv_t mv);
        logic [LEVEL_W-1:0] lv;
        lv = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (mv > LADDER[i])
            begin
                lv = LEVEL_W'(i + 1);
            end
        end
        return lv;
    endfunction

endpackage

>>> hw/rtl/bgcd_cfg.sv
// register file for the charge detection thresholds
`timescale 1ns / 1ps

module bgcd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bgcd_pkg::cfg_t      cfg
);

    bgcd_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_diff <= bgcd_pkg::START_DIFF_RST;
            cfg_reg.stop_diff  <= bgcd_pkg::STOP_DIFF_RST;
            cfg_reg.start_volt <= bgcd_pkg::START_VOLT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                bgcd_pkg::REG_START_DIFF: cfg_reg.start_diff <= pwdata[10:0];
                bgcd_pkg::REG_STOP_DIFF:  cfg_reg.stop_diff  <= pwdata[9:0];
                bgcd_pkg::REG_START_VOLT: cfg_reg.start_volt <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bgcd_pkg::REG_START_DIFF: prdata = {21'b0, cfg_reg.start_diff};
            bgcd_pkg::REG_STOP_DIFF:  prdata = {22'b0, cfg_reg.stop_diff};
            bgcd_pkg::REG_START_VOLT: prdata = {19'b0, cfg_reg.start_volt};
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/bgcd_scale.sv
// first stage: millivolt scaling and current difference
`timescale 1ns / 1ps

module bgcd_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [15:0]           raw_voltage,
    input  logic [15:0]           raw_current,
    input  logic                  mute,
    input  logic                  restart,
    input  logic                  down_load,
    output logic                  mid_load,
    output logic                  mid_valid,
    output bgcd_pkg::mid_t        mid
);

    logic                  mid_valid_reg;
    bgcd_pkg::mid_t        mid_reg;
    bgcd_pkg::mid_t        mid_next;

    logic signed [16:0]    delta;
    logic [15:0]           delta_mag;
    logic [19:0]           delta_x10;
    logic [42:0]           q11_prod;
    logic [15:0]           q11;
    logic [31:0]           roll_prod;

    assign mid_load  = !mid_valid_reg || down_load;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    always_comb
    begin
        roll_prod = 32'(raw_voltage) * 32'(bgcd_pkg::ROLL_SCALE);
        delta     = $signed({1'b0, raw_voltage}) - $signed({1'b0, raw_current});
        delta_mag = delta[16] ? 16'(-delta) : delta[15:0];
        delta_x10 = 20'({delta_mag, 3'b000}) + 20'({delta_mag, 1'b0});
        // truncation toward zero: divide the magnitude, then restore the sign
        q11_prod  = 43'(delta_x10) * 43'(bgcd_pkg::RECIP11);
        q11       = q11_prod[bgcd_pkg::RECIP11_SHIFT +: 16];

        mid_next.rolling = roll_prod[31:16];
        mid_next.diff    = delta[16] ? -$signed({1'b0, q11}) : $signed({1'b0, q11});
        mid_next.mute    = mute;
        mid_next.restart = restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_load)
        begin
            mid_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_load && in_valid)
        begin
            mid_reg <= mid_next;
        end
    end

endmodule

>>> hw/rtl/bgcd_track.sv
// second stage: compensation, charge detection, slewed display and level
`timescale 1ns / 1ps

module bgcd_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgcd_pkg::cfg_t        cfg,
    input  logic                  mid_valid,
    input  bgcd_pkg::mid_t        mid,
    output logic                  down_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            level,
    output logic                  charging,
    output bgcd_pkg::mv_t         shown_millivolts,
    output bgcd_pkg::mv_t         estimated_millivolts,
    output logic                  indicator_changed
);

    // tracking state
    logic                  charging_reg;
    bgcd_pkg::mv_t         shown_reg;
    logic [3:0]            last_level_reg;
    logic                  last_mute_reg;

    // result register
    logic                  out_valid_reg;
    logic [3:0]            level_reg;
    bgcd_pkg::mv_t         est_reg;
    logic                  changed_reg;

    logic                  item_load;
    logic [15:0]           diff_mag;
    logic [19:0]           diff_x10;
    logic [43:0]           q17_prod;
    logic [15:0]           q17;
    bgcd_pkg::mv_t         q17_s;
    bgcd_pkg::mv_t         est;
    logic                  chg_base;
    bgcd_pkg::mv_t         shown_base;
    logic [3:0]            level_prev;
    bgcd_pkg::mv_t         shown_seed;
    bgcd_pkg::mv_t         shown_next;
    logic                  charging_next;
    logic [3:0]            level_next;
    logic                  changed_next;
    logic signed [16:0]    start_diff_x;
    logic signed [16:0]    stop_diff_x;

    assign down_load = !out_valid_reg || out_ready;
    assign item_load = down_load && mid_valid;

    assign out_valid            = out_valid_reg;
    assign level                = level_reg;
    assign charging             = charging_reg;
    assign shown_millivolts     = shown_reg;
    assign estimated_millivolts = est_reg;
    assign indicator_changed    = changed_reg;

    always_comb
    begin
        diff_mag = mid.diff[16] ? 16'(-mid.diff) : mid.diff[15:0];
        diff_x10 = 20'({diff_mag, 3'b000}) + 20'({diff_mag, 1'b0});
        q17_prod = 44'(diff_x10) * 44'(bgcd_pkg::RECIP17);
        q17      = q17_prod[bgcd_pkg::RECIP17_SHIFT +: 16];
        q17_s    = $signed({2'b00, q17});
        est      = $signed({2'b00, mid.rolling}) + (mid.diff[16] ? -q17_s : q17_s);

        // restart clears the state ahead of this item
        chg_base   = mid.restart ? 1'b0 : charging_reg;
        shown_base = mid.restart ? '0 : shown_reg;
        level_prev = mid.restart ? bgcd_pkg::LEVEL_NONE : last_level_reg;

        shown_seed = (shown_base == '0) ? est : shown_base;

        start_diff_x = $signed({{6{cfg.start_diff[10]}}, cfg.start_diff});
        stop_diff_x  = $signed({7'b0, cfg.stop_diff});

        if (!chg_base)
        begin
            shown_next    = (est < shown_seed) ? shown_seed - 18'sd1 : shown_seed;
            charging_next = (mid.diff < start_diff_x) ||
                            (mid.rolling > 16'(cfg.start_volt));
        end
        else
        begin
            shown_next    = (est > shown_seed) ? shown_seed + 18'sd1 : shown_seed;
            charging_next = !(mid.diff > stop_diff_x);
        end

        level_next   = bgcd_pkg::level_of(shown_next);
        changed_next = (level_next != level_prev) || (chg_base != charging_next) ||
                       (mid.mute != last_mute_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            charging_reg   <= 1'b0;
            shown_reg      <= '0;
            last_level_reg <= bgcd_pkg::LEVEL_NONE;
            last_mute_reg  <= 1'b0;
        end
        else
        begin
            if (down_load)
            begin
                out_valid_reg <= mid_valid;
            end
            if (item_load)
            begin
                charging_reg   <= charging_next;
                shown_reg      <= shown_next;
                last_level_reg <= level_next;
                last_mute_reg  <= mid.mute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            level_reg   <= level_next;
            est_reg     <= est;
            changed_reg <= changed_next;
        end
    end

`ifndef SYNTH
    a_restart_flags_change: assert property (@(posedge clk) disable iff (!rst_n)
        (item_load && mid.restart) |=> changed_reg)
        else $error("restart item did not report an indicator change");

    a_fall_only: assert property (@(posedge clk) disable iff (!rst_n)
        (item_load && !mid.restart && !charging_reg && shown_reg != '0)
        |=> (shown_reg <= $past(shown_reg)) && (shown_reg >= $past(shown_reg) - 18'sd1))
        else $error("display rose or fell by more than one while discharging");

    a_rise_only: assert property (@(posedge clk) disable iff (!rst_n)
        (item_load && !mid.restart && charging_reg && shown_reg != '0)
        |=> (shown_reg >= $past(shown_reg)) && (shown_reg <= $past(shown_reg) + 18'sd1))
        else $error("display fell or rose by more than one while charging");

    a_level_tracks_display: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg == last_level_reg) && (level_reg <= 4'd10))
        else $error("result level disagrees with stored level");
`endif

endmodule

>>> hw/rtl/battery_gauge_with_charge_detect_unit.sv
// top level of the battery gauge with charge detection
`timescale 1ns / 1ps

// channel  | direction | contents
// s_*      | in        | one sample item: raw sums, mute, restart
// m_*      | out       | one result item per sample
// apb      | in/out    | threshold registers at 0x0, 0x4, 0x8
//
// one item per cycle while m_tready keeps up; m_tvalid follows the accepting
// edge through the input register, scaling stage and tracking/result stage
// the tracking stage updates charge and display state as it loads each item,
// so consecutive items never wait on each other
// rst_n clears valid bits and tracking state; thresholds return to defaults
// a stalled m_tready holds every full stage at once, bubbles still fill

module battery_gauge_with_charge_detect_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_voltage[15:0], raw_current[31:16], mute[32],
                                   // restart[33], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // level[3:0], charging[4], shown_millivolts[22:5],
                                   // estimated_millivolts[40:23], indicator_changed[41],
                                   // zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               in_valid_reg;
    logic [15:0]        rv_reg;
    logic [15:0]        ra_reg;
    logic               mute_reg;
    logic               restart_reg;

    logic               mid_load;
    logic               mid_valid;
    logic               down_load;
    bgcd_pkg::mid_t     mid;
    bgcd_pkg::cfg_t     cfg;

    logic [3:0]         level;
    logic               charging;
    bgcd_pkg::mv_t      shown_mv;
    bgcd_pkg::mv_t      est_mv;
    logic               changed;

    assign s_tready = !in_valid_reg || mid_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            rv_reg      <= s_tdata[15:0];
            ra_reg      <= s_tdata[31:16];
            mute_reg    <= s_tdata[32];
            restart_reg <= s_tdata[33];
        end
    end

    bgcd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgcd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .raw_voltage (rv_reg),
        .raw_current (ra_reg),
        .mute        (mute_reg),
        .restart     (restart_reg),
        .down_load   (down_load),
        .mid_load    (mid_load),
        .mid_valid   (mid_valid),
        .mid         (mid)
    );

    bgcd_track u_track (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .mid_valid            (mid_valid),
        .mid                  (mid),
        .down_load            (down_load),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .level                (level),
        .charging             (charging),
        .shown_millivolts     (shown_mv),
        .estimated_millivolts (est_mv),
        .indicator_changed    (changed)
    );

    assign m_tdata = {6'b0, changed, est_mv, shown_mv, charging, level};

endmodule

>>> tb/tb.sv
// self-checking testbench for the battery gauge with charge detection
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 80;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [3:0]     level;
        logic           charging;
        bgcd_pkg::mv_t  shown;
        bgcd_pkg::mv_t  est;
        logic           changed;
    } gauge_res_t;

    typedef struct {
        logic [15:0] volt_raw;
        logic [15:0] amp_raw;
        logic        mute;
        logic        restart;
        bit          pinned;
        gauge_res_t  res;
    } probe_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // raw_voltage[15:0], raw_current[31:16], mute[32], restart[33]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // level[3:0], charging[4], shown[22:5], estimate[40:23],
                            // indicator_changed[41]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    battery_gauge_with_charge_detect_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // gauge shadow: thresholds and tracking state
    int  thr_start_diff = -25;
    int  thr_stop_diff  = 25;
    int  thr_start_volt = 4200;
    bit  trk_charging   = 1'b0;
    int  trk_shown      = 0;
    int  trk_last_level = int'(bgcd_pkg::LEVEL_NONE);
    bit  trk_last_mute  = 1'b0;
    int  gauge_steps [10] = '{3478, 3549, 3619, 3655, 3725, 3761, 3866, 3927, 4027, 4175};

    gauge_res_t  expected_q [$];
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int          items_in     = 0;
    int          results_out  = 0;
    int          charging_out = 0;
    int          restarts_in  = 0;
    int          cfg_writes   = 0;
    logic [10:0] levels_seen  = '0;

    // stimulus side channel: a typed expectation rides along with the item
    bit          pin_valid = 1'b0;
    gauge_res_t  pin_res   = '0;
    bit          steady    = 1'b0;
    bit          hold_req  = 1'b0;
    int          walk_raw  = 7000;
    bit          mute_state = 1'b0;

    probe_row_t probes [22] = '{
        // right after reset the change flag is set by the missing level
        '{16'd0,     16'd0,     1'b0, 1'b0, 1'b1, '{4'd0, 1'b0, 18'sd0, 18'sd0, 1'b1}},
        '{16'd0,     16'd0,     1'b1, 1'b0, 1'b1, '{4'd0, 1'b0, 18'sd0, 18'sd0, 1'b1}},
        '{16'd0,     16'd0,     1'b1, 1'b0, 1'b1, '{4'd0, 1'b0, 18'sd0, 18'sd0, 1'b0}},
        '{16'd65535, 16'd0,     1'b0, 1'b1, 1'b1,
          '{4'd10, 1'b1, 18'sd71344, 18'sd71344, 1'b1}},
        '{16'd65535, 16'd0,     1'b0, 1'b0, 1'b1,
          '{4'd10, 1'b0, 18'sd71344, 18'sd71344, 1'b1}},
        '{16'd0,     16'd65535, 1'b0, 1'b1, 1'b1,
          '{4'd0, 1'b1, -18'sd35045, -18'sd35045, 1'b1}},
        '{16'd0,     16'd65535, 1'b1, 1'b0, 1'b1,
          '{4'd0, 1'b1, -18'sd35045, -18'sd35045, 1'b1}},
        '{16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1,
          '{4'd10, 1'b1, 18'sd36299, 18'sd36299, 1'b1}},
        // ladder edges at the lowest and the full threshold
        '{16'd6280,  16'd6280,  1'b1, 1'b1, 1'b0, '0},
        '{16'd6281,  16'd6281,  1'b1, 1'b1, 1'b0, '0},
        '{16'd7539,  16'd7539,  1'b1, 1'b1, 1'b0, '0},
        '{16'd7540,  16'd7540,  1'b1, 1'b1, 1'b0, '0},
        '{16'd7540,  16'd7540,  1'b0, 1'b0, 1'b0, '0},
        // charge hysteresis by current difference
        '{16'd20000, 16'd19000, 1'b0, 1'b1, 1'b0, '0},
        '{16'd10000, 16'd10100, 1'b0, 1'b0, 1'b0, '0},
        '{16'd10000, 16'd10000, 1'b0, 1'b0, 1'b0, '0},
        '{16'd10100, 16'd10000, 1'b0, 1'b0, 1'b0, '0},
        '{16'd7700,  16'd7700,  1'b1, 1'b1, 1'b0, '0},
        '{16'd7000,  16'd7100,  1'b1, 1'b0, 1'b0, '0},
        '{16'hAAAA,  16'h5555,  1'b1, 1'b0, 1'b0, '0},
        // restart while mute flips back
        '{16'h5555,  16'hAAAA,  1'b0, 1'b1, 1'b0, '0},
        '{16'd1,     16'd65534, 1'b0, 1'b0, 1'b0, '0}
    };

    function automatic gauge_res_t gauge_track(input logic [15:0] volt_raw,
                                               input logic [15:0] amp_raw,
                                               input logic mute, input logic restart);
        longint     rolling;
        longint     diff;
        longint     est;
        bit         was_charging;
        int         lvl;
        gauge_res_t r;
        if (restart)
        begin
            trk_charging   = 1'b0;
            trk_shown      = 0;
            trk_last_level = int'(bgcd_pkg::LEVEL_NONE);
        end
        rolling = (longint'(volt_raw) * 36300) / 65536;
        diff    = ((longint'(volt_raw) - longint'(amp_raw)) * 10) / 11;
        est     = rolling + (diff * 10) / 17;
        was_charging = trk_charging;
        // an empty display snaps to the estimate before slewing
        if (trk_shown == 0)
            trk_shown = int'(est);
        if (!trk_charging)
        begin
            if (est < trk_shown)
                trk_shown--;
            if (diff < thr_start_diff || rolling > thr_start_volt)
                trk_charging = 1'b1;
        end
        else
        begin
            if (est > trk_shown)
                trk_shown++;
            if (diff > thr_stop_diff)
                trk_charging = 1'b0;
        end
        lvl = 0;
        for (int i = 0; i < 10; i++)
            if (trk_shown > gauge_steps[i])
                lvl = i + 1;
        r.level    = 4'(lvl);
        r.charging = trk_charging;
        r.shown    = bgcd_pkg::mv_t'(trk_shown);
        r.est      = bgcd_pkg::mv_t'(est);
        r.changed  = (lvl != trk_last_level) || (was_charging != trk_charging)
                     || (mute != trk_last_mute);
        trk_last_level = lvl;
        trk_last_mute  = mute;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready  = 1'b0;
            end
            else
                m_tready = steady || ($urandom_range(0, 99) >= 7);
        end
    end

    // acceptance, prediction, checking and watchdog
    always @(posedge clk)
    begin
        gauge_res_t exp_r;
        gauge_res_t got;
        if (s_tvalid && s_tready)
        begin
            exp_r = gauge_track(s_tdata[15:0], s_tdata[31:16], s_tdata[32], s_tdata[33]);
            expected_q.push_back(pin_valid ? pin_res : exp_r);
            items_in++;
            if (s_tdata[33])
                restarts_in++;
        end
        if (m_tvalid && m_tready)
        begin
            got.level    = m_tdata[3:0];
            got.charging = m_tdata[4];
            got.shown    = m_tdata[22:5];
            got.est      = m_tdata[40:23];
            got.changed  = m_tdata[41];
            results_out++;
            if (got.charging)
                charging_out++;
            if (got.level <= 4'd10)
                levels_seen[got.level] = 1'b1;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.level !== exp_r.level)
                begin
                    $error("level: expected %0d, got %0d", exp_r.level, got.level);
                    fail_count++;
                end
                if (got.charging !== exp_r.charging)
                begin
                    $error("charging: expected %0d, got %0d", exp_r.charging, got.charging);
                    fail_count++;
                end
                if (got.shown !== exp_r.shown)
                begin
                    $error("shown_millivolts: expected %0d, got %0d", exp_r.shown, got.shown);
                    fail_count++;
                end
                if (got.est !== exp_r.est)
                begin
                    $error("estimated_millivolts: expected %0d, got %0d", exp_r.est, got.est);
                    fail_count++;
                end
                if (got.changed !== exp_r.changed)
                begin
                    $error("indicator_changed: expected %0d, got %0d",
                           exp_r.changed, got.changed);
                    fail_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic offer_sample(input logic [15:0] volt_raw, input logic [15:0] amp_raw,
                                input logic mute, input logic restart,
                                input bit pinned, input gauge_res_t res);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 7) ? 1 : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid  = 1'b1;
        s_tdata   = {6'b0, restart, mute, amp_raw, volt_raw};
        pin_valid = pinned;
        pin_res   = res;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input bgcd_pkg::reg_idx_t idx, input int value);
        logic [31:0] mask;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (idx)
            bgcd_pkg::REG_START_DIFF:
            begin
                thr_start_diff = int'($signed(value[10:0]));
                mask = 32'h7FF;
            end
            bgcd_pkg::REG_STOP_DIFF:
            begin
                thr_stop_diff = int'(value[9:0]);
                mask = 32'h3FF;
            end
            default:
            begin
                thr_start_volt = int'(value[12:0]);
                mask = 32'h1FFF;
            end
        endcase
        cfg_writes++;
        // read back through the same port
        @(negedge clk);
        psel   = 1'b1;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (32'(value) & mask))
        begin
            $error("prdata of %s: expected %h, got %h", idx.name(),
                   32'(value) & mask, prdata & mask);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // mostly a slowly drifting battery near the ladder, some raw noise
    task automatic next_sample(output logic [15:0] volt_raw, output logic [15:0] amp_raw,
                               output logic mute, output logic restart);
        int amp;
        restart = ($urandom_range(0, 99) < 4);
        if ($urandom_range(0, 99) < 8)
            mute_state = ~mute_state;
        mute = mute_state;
        if ($urandom_range(0, 99) < 15)
        begin
            volt_raw = 16'($urandom);
            amp_raw  = 16'($urandom);
        end
        else
        begin
            if (restart)
                walk_raw = $urandom_range(5600, 8400);
            else
                walk_raw = walk_raw + $urandom_range(0, 40) - 20;
            if (walk_raw < 5600)
                walk_raw = 5600;
            if (walk_raw > 8400)
                walk_raw = 8400;
            amp = walk_raw + $urandom_range(0, 160) - 80;
            volt_raw = 16'(walk_raw);
            amp_raw  = 16'(amp);
        end
    endtask

    initial
    begin
        int          cfg_table [5][3];
        int          sd;
        int          sp;
        int          sv;
        logic [15:0] volt_raw;
        logic [15:0] amp_raw;
        logic        mute;
        logic        restart;
        cfg_table = '{'{-1000, 1000, 8000}, '{0, 0, 0}, '{-1024, 1023, 8191},
                      '{-25, 25, 4200}, '{-200, 300, 3900}};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probes[i])
            offer_sample(probes[i].volt_raw, probes[i].amp_raw, probes[i].mute,
                         probes[i].restart, probes[i].pinned, probes[i].res);
        drain_results();

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            if (phase <= 5)
            begin
                sd = cfg_table[phase-1][0];
                sp = cfg_table[phase-1][1];
                sv = cfg_table[phase-1][2];
            end
            else
            begin
                sd = -$urandom_range(0, 1000);
                sp = $urandom_range(0, 1000);
                sv = (phase == PHASES) ? $urandom_range(0, 8000) : $urandom_range(3400, 4600);
            end
            cfg_write(bgcd_pkg::REG_START_DIFF, sd);
            cfg_write(bgcd_pkg::REG_STOP_DIFF, sp);
            cfg_write(bgcd_pkg::REG_START_VOLT, sv);
            steady = (phase == 3);
            if (phase == 2 || phase == 7)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                next_sample(volt_raw, amp_raw, mute, restart);
                offer_sample(volt_raw, amp_raw, mute, restart, 1'b0, '0);
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        fail_count += expected_q.size();
        $display("covered %0d samples (%0d restarts) over %0d threshold writes",
                 items_in, restarts_in, cfg_writes);
        $display("checked %0d results, %0d while charging, levels seen %b",
                 results_out, charging_out, levels_seen);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
